// File: src/bba_pkg.sv
// shared types, codes and default sizes for the bitmap block allocator
package bba_pkg;

  // default sizes
  localparam int NUM_BLOCKS_DEF     = 256;
  localparam int RESERVED_START_DEF = 0;
  localparam int RESERVED_COUNT_DEF = 1;

  // bits per map word
  localparam int WORD_BITS = 64;

  // operation codes
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_USED  = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RMW
  } state_t;

endpackage

// File: src/bitmap_block_allocator_core.sv
// first-fit bitmap block allocator with the used map held in a synchronous memory
//
//  channel | direction | transfer marked by      | fields
//  --------+-----------+-------------------------+-----------------------------------------
//  command | in        | start high, busy low    | kind, target_block
//  result  | out       | done high for one cycle | status, granted_block, used_count,
//          |           |                         | free_count
//
// allocate: reads the map one 64-bit word per cycle, starting at word 0, and stops
//   at the first word with a free bit, or reports full after the last word
// request and release of an in-range block take one read-modify-write; out-of-range
//   ids and the unused kind code answer in the next cycle
// reset: the map reads as empty except for the reserved blocks, through per-word valid
//   bits, so no clearing pass is needed and a command may follow reset at once
// the receiver cannot stall results; a new command may be taken in the cycle done is high
module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS     = bba_pkg::NUM_BLOCKS_DEF,
  parameter int RESERVED_START = bba_pkg::RESERVED_START_DEF,
  parameter int RESERVED_COUNT = bba_pkg::RESERVED_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] kind,
  input  logic [8:0] target_block,
  output logic       done,
  output logic [1:0] status,
  output logic [7:0] granted_block,
  output logic [8:0] used_count,
  output logic [8:0] free_count
);

  localparam int WB        = bba_pkg::WORD_BITS;
  localparam int MAP_WORDS = (NUM_BLOCKS + WB - 1) / WB;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = $clog2(NUM_BLOCKS + 1);
  localparam int OW        = (CW > 9) ? CW : 9;
  // reserved blocks that actually fall inside the map
  localparam int RES_END   = (RESERVED_START + RESERVED_COUNT < NUM_BLOCKS)
                             ? (RESERVED_START + RESERVED_COUNT) : NUM_BLOCKS;
  localparam int RES_USED  = (RES_END > RESERVED_START) ? (RES_END - RESERVED_START) : 0;

  // map memory, registered read
  logic [WB-1:0] mem [MAP_WORDS];
  logic [WB-1:0] rdata;
  logic [MAP_WORDS-1:0] word_valid;

  bba_pkg::state_t state, state_next;

  // latched command
  logic [1:0]    cmd_kind;
  logic [8:0]    cmd_id;
  logic [WW-1:0] word_idx, word_idx_next;
  logic [CW-1:0] used_total, used_total_next;

  // memory port controls from the output decode
  logic          rd_en;
  logic [WW-1:0] rd_addr;
  logic          wr_en;
  logic [WW-1:0] wr_addr;
  logic [WB-1:0] wr_data;

  // result loading
  logic       res_load;
  logic [1:0] res_status;
  logic [7:0] res_granted;

  // datapath helpers
  logic [WW-1:0] id_word;
  logic          id_in_range;
  logic [WB-1:0] reset_word;
  logic [WB-1:0] tail_mask;
  logic [WB-1:0] cur_word;
  logic [WB-1:0] scan_word;
  logic          scan_hit;
  logic [5:0]    scan_pos;
  logic [WW+5:0] scan_block;
  logic [WB-1:0] id_mask;
  logic          id_used;
  logic [OW-1:0] used_ext;
  logic [OW-1:0] free_ext;

  assign busy = (state != bba_pkg::ST_IDLE);

  // word index and range check of the named block
  assign id_word     = WW'({{WW{1'b0}}, target_block[8:6]});
  assign id_in_range = (int'(target_block) < NUM_BLOCKS);

  // reset image and out-of-map bits of the word under work
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      int gid;
      gid = int'(word_idx) * WB + b;
      reset_word[b] = (gid >= RESERVED_START) && (gid < RES_END);
      tail_mask[b]  = (gid >= NUM_BLOCKS);
    end
  end

  // a word never written reads as its reset image
  assign cur_word  = word_valid[word_idx] ? rdata : reset_word;
  assign scan_word = cur_word | tail_mask;
  assign scan_hit  = ~&scan_word;

  // lowest free bit of the scanned word
  always_comb begin
    scan_pos = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        scan_pos = 6'(b);
      end
    end
  end

  assign scan_block = {word_idx, scan_pos};
  assign id_mask    = {{(WB-1){1'b0}}, 1'b1} << cmd_id[5:0];
  assign id_used    = |(cur_word & id_mask);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_IDLE: begin
        if (start) begin
          if (kind == bba_pkg::KIND_ALLOC) begin
            state_next = bba_pkg::ST_SCAN;
          end else if ((kind inside {bba_pkg::KIND_REQUEST, bba_pkg::KIND_RELEASE})
                       && id_in_range) begin
            state_next = bba_pkg::ST_RMW;
          end
        end
      end
      bba_pkg::ST_SCAN: begin
        if (scan_hit || word_idx == WW'(MAP_WORDS - 1)) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_RMW: begin
        state_next = bba_pkg::ST_IDLE;
      end
      default: state_next = bba_pkg::ST_IDLE;
    endcase
  end

  // memory controls, count update and result
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = word_idx;
    wr_en           = 1'b0;
    wr_addr         = word_idx;
    wr_data         = cur_word;
    word_idx_next   = word_idx;
    used_total_next = used_total;
    res_load        = 1'b0;
    res_status      = bba_pkg::STATUS_OK;
    res_granted     = '0;
    unique case (state)
      bba_pkg::ST_IDLE: begin
        if (start) begin
          unique case (kind) inside
            bba_pkg::KIND_ALLOC: begin
              // scan starts at word 0
              rd_en         = 1'b1;
              rd_addr       = '0;
              word_idx_next = '0;
            end
            bba_pkg::KIND_REQUEST, bba_pkg::KIND_RELEASE: begin
              if (id_in_range) begin
                rd_en         = 1'b1;
                rd_addr       = id_word;
                word_idx_next = id_word;
              end else begin
                res_load   = 1'b1;
                res_status = bba_pkg::STATUS_RANGE;
              end
            end
            default: begin
              // unused code: answers ok, touches nothing
              res_load = 1'b1;
            end
          endcase
        end
      end
      bba_pkg::ST_SCAN: begin
        if (scan_hit) begin
          wr_en           = 1'b1;
          wr_data         = cur_word | ({{(WB-1){1'b0}}, 1'b1} << scan_pos);
          used_total_next = used_total + 1'b1;
          res_load        = 1'b1;
          res_granted     = 8'(scan_block);
        end else if (word_idx == WW'(MAP_WORDS - 1)) begin
          res_load   = 1'b1;
          res_status = bba_pkg::STATUS_FULL;
        end else begin
          // fetch the next word while this one is checked
          rd_en         = 1'b1;
          rd_addr       = WW'(word_idx + 1'b1);
          word_idx_next = WW'(word_idx + 1'b1);
        end
      end
      bba_pkg::ST_RMW: begin
        res_load = 1'b1;
        if (cmd_kind == bba_pkg::KIND_REQUEST) begin
          if (id_used) begin
            res_status = bba_pkg::STATUS_USED;
          end else begin
            wr_en           = 1'b1;
            wr_data         = cur_word | id_mask;
            used_total_next = used_total + 1'b1;
            res_granted     = cmd_id[7:0];
          end
        end else if (id_used) begin
          // release of a used block; a free one is left as is
          wr_en           = 1'b1;
          wr_data         = cur_word & ~id_mask;
          used_total_next = used_total - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // counts reported with the result
  assign used_ext = OW'(used_total_next);
  assign free_ext = OW'(NUM_BLOCKS) - used_ext;

  // map memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bba_pkg::ST_IDLE;
      word_valid <= '0;
      used_total <= CW'(RES_USED);
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      used_total <= used_total_next;
      done       <= res_load;
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    word_idx <= word_idx_next;
    if (start && !busy) begin
      cmd_kind <= kind;
      cmd_id   <= target_block;
    end
    if (res_load) begin
      status        <= res_status;
      granted_block <= res_granted;
      used_count    <= 9'(used_ext);
      free_count    <= 9'(free_ext);
    end
  end

endmodule

// File: src/bba_checker.sv
// port-level checks for the bitmap block allocator, bound to the top level
module bba_checker #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] kind,
  input logic [8:0] target_block,
  input logic       done,
  input logic [1:0] status,
  input logic [7:0] granted_block,
  input logic [8:0] used_count,
  input logic [8:0] free_count
);

  localparam logic [8:0] NB9 = 9'(NUM_BLOCKS);

  // the two counts always cover the whole map
  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> (9'(used_count + free_count) == NB9))
    else $error("used and free counts do not add up");

  // failed operations grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (done && status != bba_pkg::STATUS_OK) |-> (granted_block == 8'd0))
    else $error("grant on failed operation");

  // a full report means no free block is left
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    (done && status == bba_pkg::STATUS_FULL) |-> (free_count == 9'd0))
    else $error("full reported with free blocks");

  // a result always leaves the block ready for the next command
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while a result is shown");

  // an out-of-range id is answered in the next cycle
  a_range_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == bba_pkg::KIND_REQUEST || kind == bba_pkg::KIND_RELEASE)
     && (int'(target_block) >= NUM_BLOCKS))
    |=> (done && status == bba_pkg::STATUS_RANGE))
    else $error("out-of-range id not reported");

endmodule

bind bitmap_block_allocator_core bba_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_bba_checker (.*);
